// ----- hw/rtl/bootp_reply_option_parser_core_macros.svh -----
// Assertion macros shared by the BOOTP reply parser checkers.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef BOOTP_REPLY_OPTION_PARSER_CORE_MACROS_SVH
`define BOOTP_REPLY_OPTION_PARSER_CORE_MACROS_SVH

// Same-cycle implication.
`define BPRS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bootp parser check failed");

// Next-cycle implication.
`define BPRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bootp parser check failed");

`endif

// ----- hw/rtl/bootp_prs_pkg.sv -----
// Shared constants, types and helper functions of the BOOTP reply parser.
// No dependencies; used by every RTL file of the block.
`timescale 1ns / 1ps

package bootp_prs_pkg;

  // Packet geometry
  localparam int HEADER_BYTES     = 36;
  localparam int VENDOR_BYTES     = 128;
  localparam int MAX_PACKET_BYTES = 512;

  localparam int OFS_HTYPE  = HEADER_BYTES + 1;
  localparam int OFS_HLEN   = HEADER_BYTES + 2;
  localparam int OFS_YIADDR = HEADER_BYTES + 16;
  localparam int OFS_CHADDR = HEADER_BYTES + 28;
  localparam int OFS_VEND   = HEADER_BYTES + 236;

  // Offset counter saturates at MAX_PACKET_BYTES, so it must hold that value.
  localparam int OFS_W = $clog2(MAX_PACKET_BYTES + 1);

  localparam int MAC_BYTES = 6;
  localparam int IP_BYTES  = 4;
  localparam int IP_W      = 8 * IP_BYTES;
  localparam int MAC_W     = 8 * MAC_BYTES;
  localparam int NUM_ADDR  = 6;
  localparam int CNT_W     = $clog2(IP_BYTES + 1);

  // Front-to-back queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Result queue
  localparam int RES_DEPTH  = 2;
  localparam int RPTR_W     = $clog2(RES_DEPTH);
  localparam int RCNT_W     = $clog2(RES_DEPTH + 1);

  // Header field values
  localparam logic [7:0] HTYPE_ETHER = 8'd1;
  localparam logic [7:0] HLEN_ETHER  = 8'd6;

  // Option codes
  localparam logic [7:0] OPT_PAD        = 8'd0;
  localparam logic [7:0] OPT_END        = 8'hFF;
  localparam logic [7:0] OPT_MASK       = 8'd1;
  localparam logic [7:0] OPT_ROUTER     = 8'd3;
  localparam logic [7:0] OPT_DNS        = 8'd6;
  localparam logic [7:0] OPT_COOKIE_SRV = 8'd8;
  localparam logic [7:0] OPT_RLP_SRV    = 8'd11;
  localparam logic [7:0] MASK_LEN       = 8'd4;

  // Address register indexes
  localparam logic [2:0] ADDR_CLIENT = 3'd0;
  localparam logic [2:0] ADDR_MASK   = 3'd1;
  localparam logic [2:0] ADDR_ROUTER = 3'd2;
  localparam logic [2:0] ADDR_DNS    = 3'd3;
  localparam logic [2:0] ADDR_AUTH   = 3'd4;
  localparam logic [2:0] ADDR_FILE   = 3'd5;

  typedef enum logic [2:0] {
    PH_COOKIE,
    PH_CODE,
    PH_LEN,
    PH_VALUE,
    PH_STOP,
    PH_BAD
  } phase_e;

  // One queue word: a packet byte plus what the front learned about it.
  typedef struct packed {
    logic [7:0]      data;
    logic            last;    // final byte of the packet
    logic            acc;     // packet accepted (valid with last)
    logic            parse;   // byte lies in the vendor area of a matching reply
    logic            commit;  // first vendor byte: commit offered address
    logic            vi_lt4;  // vendor index below four
    logic [1:0]      vi_lo;
    logic [IP_W-1:0] ip;      // offered address (valid with commit)
  } entry_t;

  typedef struct packed {
    logic                          accepted;
    logic                          cookie_ok;
    logic [NUM_ADDR-1:0][IP_W-1:0] addr;
  } result_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] idx;
  } addr_sel_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0: b = 8'd99;
      2'd1: b = 8'd130;
      2'd2: b = 8'd83;
      2'd3: b = 8'd99;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

  function automatic addr_sel_t reg_for_code(input logic [7:0] code);
    addr_sel_t s;
    s.hit = 1'b1;
    priority case (code)
      OPT_MASK:       s.idx = ADDR_MASK;
      OPT_ROUTER:     s.idx = ADDR_ROUTER;
      OPT_DNS:        s.idx = ADDR_DNS;
      OPT_COOKIE_SRV: s.idx = ADDR_AUTH;
      OPT_RLP_SRV:    s.idx = ADDR_FILE;
      default: begin
        s.hit = 1'b0;
        s.idx = ADDR_CLIENT;
      end
    endcase
    return s;
  endfunction

endpackage

// ----- hw/rtl/bootp_prs_front.sv -----
// Front end: byte offset, header match, offered address and bound flag.
// Emits one classified word per byte into the queue until bound. Uses bootp_prs_pkg.
`timescale 1ns / 1ps

module bootp_prs_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  input  logic [bootp_prs_pkg::MAC_W-1:0] cfg_mac_i,
  input  logic                      byte_valid_i,
  input  logic [7:0]                data_byte_i,
  input  logic                      last_byte_i,
  output logic                      q_push_o,
  output bootp_prs_pkg::entry_t     q_entry_o
);

  localparam int W = bootp_prs_pkg::OFS_W;

  logic [W-1:0]                     ofs_q, ofs_d;
  logic                             match_q, match_d;
  logic                             bound_q, bound_d;
  logic [bootp_prs_pkg::IP_W-1:0]   shadow_q, shadow_d;
  logic [bootp_prs_pkg::MAC_W-1:0]  mac_q;
  logic [bootp_prs_pkg::MAC_BYTES-1:0][7:0] mac_bytes;
  logic [W-1:0]                     vi;
  logic [2:0]                       mac_sel;
  logic                             in_range, in_yiaddr, in_chaddr, vend;

  assign mac_bytes = mac_q;

  always_comb begin
    vi        = ofs_q - W'(bootp_prs_pkg::OFS_VEND);
    mac_sel   = 3'(bootp_prs_pkg::MAC_BYTES - 1) - 3'(ofs_q - W'(bootp_prs_pkg::OFS_CHADDR));
    in_range  = ofs_q < W'(bootp_prs_pkg::MAX_PACKET_BYTES);
    in_yiaddr = (ofs_q >= W'(bootp_prs_pkg::OFS_YIADDR)) &&
                (ofs_q <  W'(bootp_prs_pkg::OFS_YIADDR + bootp_prs_pkg::IP_BYTES));
    in_chaddr = (ofs_q >= W'(bootp_prs_pkg::OFS_CHADDR)) &&
                (ofs_q <  W'(bootp_prs_pkg::OFS_CHADDR + bootp_prs_pkg::MAC_BYTES));

    ofs_d    = ofs_q;
    match_d  = match_q;
    bound_d  = bound_q;
    shadow_d = shadow_q;

    if (in_range) begin
      if (ofs_q == W'(bootp_prs_pkg::OFS_HTYPE) && data_byte_i != bootp_prs_pkg::HTYPE_ETHER) begin
        match_d = 1'b0;
      end
      if (ofs_q == W'(bootp_prs_pkg::OFS_HLEN) && data_byte_i != bootp_prs_pkg::HLEN_ETHER) begin
        match_d = 1'b0;
      end
      if (in_chaddr && data_byte_i != mac_bytes[mac_sel]) begin
        match_d = 1'b0;
      end
      if (in_yiaddr) begin
        shadow_d = {shadow_q[bootp_prs_pkg::IP_W-9:0], data_byte_i};
      end
      ofs_d = ofs_q + W'(1);
    end

    vend = in_range && match_d && (ofs_q >= W'(bootp_prs_pkg::OFS_VEND));

    q_entry_o.data   = data_byte_i;
    q_entry_o.last   = last_byte_i;
    q_entry_o.acc    = match_d && (ofs_q >= W'(bootp_prs_pkg::OFS_VEND));
    q_entry_o.parse  = vend && (vi < W'(bootp_prs_pkg::VENDOR_BYTES));
    q_entry_o.commit = vend && (vi == '0);
    q_entry_o.vi_lt4 = vi < W'(4);
    q_entry_o.vi_lo  = vi[1:0];
    q_entry_o.ip     = shadow_q;

    q_push_o = byte_valid_i && !bound_q;

    if (last_byte_i) begin
      bound_d  = q_entry_o.acc;
      ofs_d    = '0;
      match_d  = 1'b1;
      shadow_d = '0;
    end

    // Nothing moves while bound or without a byte.
    if (!q_push_o) begin
      ofs_d    = ofs_q;
      match_d  = match_q;
      bound_d  = bound_q;
      shadow_d = shadow_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ofs_q    <= '0;
      match_q  <= 1'b1;
      bound_q  <= 1'b0;
      shadow_q <= '0;
      mac_q    <= '0;
    end else begin
      ofs_q    <= ofs_d;
      match_q  <= match_d;
      bound_q  <= bound_d;
      shadow_q <= shadow_d;
      if (cfg_valid_i) begin
        mac_q <= cfg_mac_i;
      end
    end
  end

endmodule

// ----- hw/rtl/bootp_prs_queue.sv -----
// Short FIFO of classified words between the front and back ends.
// Depth from bootp_prs_pkg::QUEUE_DEPTH.
`timescale 1ns / 1ps

module bootp_prs_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  bootp_prs_pkg::entry_t entry_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output bootp_prs_pkg::entry_t entry_o
);

  bootp_prs_pkg::entry_t                    mem_q [bootp_prs_pkg::QUEUE_DEPTH];
  logic [bootp_prs_pkg::QPTR_W-1:0]         wr_q, wr_d, rd_q, rd_d;
  logic [bootp_prs_pkg::QCNT_W-1:0]         cnt_q, cnt_d;
  logic                                     do_push, do_pop;

  assign full_o  = cnt_q == bootp_prs_pkg::QCNT_W'(bootp_prs_pkg::QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign entry_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? wr_q + bootp_prs_pkg::QPTR_W'(1) : wr_q;
    rd_d  = do_pop  ? rd_q + bootp_prs_pkg::QPTR_W'(1) : rd_q;
    cnt_d = cnt_q + bootp_prs_pkg::QCNT_W'(do_push) - bootp_prs_pkg::QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

// ----- hw/rtl/bootp_prs_back.sv -----
// Back end: cookie check, option walk, address registers, result FIFO.
// Consumes words from bootp_prs_queue. Uses bootp_prs_pkg.
`timescale 1ns / 1ps

module bootp_prs_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  input  bootp_prs_pkg::entry_t  q_entry_i,
  output logic                   q_pop_o,
  output logic                   res_empty_o,
  input  logic                   res_pop_i,
  output bootp_prs_pkg::result_t res_o
);

  bootp_prs_pkg::phase_e  phase_q, phase_d;
  logic [7:0]             code_q, code_d;
  logic [7:0]             rem_q, rem_d;
  logic [bootp_prs_pkg::IP_W-1:0]  val_q, val_d;
  logic [bootp_prs_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [bootp_prs_pkg::NUM_ADDR-1:0][bootp_prs_pkg::IP_W-1:0] addr_q, addr_d;
  bootp_prs_pkg::addr_sel_t sel;
  bootp_prs_pkg::result_t   res;

  bootp_prs_pkg::result_t           out_mem_q [bootp_prs_pkg::RES_DEPTH];
  logic [bootp_prs_pkg::RPTR_W-1:0] owr_q, ord_q;
  logic [bootp_prs_pkg::RCNT_W-1:0] ocnt_q;
  logic                             out_room, out_push, out_pop;
  logic [7:0]                       b;

  assign b        = q_entry_i.data;
  assign out_room = ocnt_q != bootp_prs_pkg::RCNT_W'(bootp_prs_pkg::RES_DEPTH);
  assign q_pop_o  = q_valid_i && (!q_entry_i.last || out_room);
  assign out_push = q_pop_o && q_entry_i.last;
  assign out_pop  = res_pop_i && !res_empty_o;
  assign res_empty_o = ocnt_q == '0;
  assign res_o       = out_mem_q[ord_q];
  assign sel         = bootp_prs_pkg::reg_for_code(code_q);

  always_comb begin
    phase_d = phase_q;
    code_d  = code_q;
    rem_d   = rem_q;
    val_d   = val_q;
    cnt_d   = cnt_q;
    addr_d  = addr_q;

    if (q_pop_o && q_entry_i.commit) begin
      addr_d[bootp_prs_pkg::ADDR_CLIENT] = q_entry_i.ip;
    end

    if (q_pop_o && q_entry_i.parse) begin
      unique case (phase_q)
        bootp_prs_pkg::PH_COOKIE: begin
          if (!q_entry_i.vi_lt4 || b != bootp_prs_pkg::magic_byte(q_entry_i.vi_lo)) begin
            phase_d = bootp_prs_pkg::PH_BAD;
          end else if (q_entry_i.vi_lo == 2'd3) begin
            phase_d = bootp_prs_pkg::PH_CODE;
          end
        end
        bootp_prs_pkg::PH_CODE: begin
          if (b == bootp_prs_pkg::OPT_PAD || b == bootp_prs_pkg::OPT_END) begin
            phase_d = bootp_prs_pkg::PH_STOP;
          end else begin
            code_d  = b;
            phase_d = bootp_prs_pkg::PH_LEN;
          end
        end
        bootp_prs_pkg::PH_LEN: begin
          if (code_q == bootp_prs_pkg::OPT_MASK && b != bootp_prs_pkg::MASK_LEN) begin
            phase_d = bootp_prs_pkg::PH_STOP;
          end else begin
            rem_d   = b;
            val_d   = '0;
            cnt_d   = '0;
            phase_d = (b == 8'd0) ? bootp_prs_pkg::PH_CODE : bootp_prs_pkg::PH_VALUE;
          end
        end
        bootp_prs_pkg::PH_VALUE: begin
          if (cnt_q < bootp_prs_pkg::CNT_W'(bootp_prs_pkg::IP_BYTES)) begin
            val_d = {val_q[bootp_prs_pkg::IP_W-9:0], b};
            cnt_d = cnt_q + bootp_prs_pkg::CNT_W'(1);
            // Fourth value byte completes the first address.
            if (cnt_q == bootp_prs_pkg::CNT_W'(bootp_prs_pkg::IP_BYTES - 1) && sel.hit) begin
              addr_d[sel.idx] = val_d;
            end
          end
          rem_d = rem_q - 8'd1;
          if (rem_q == 8'd1) begin
            phase_d = bootp_prs_pkg::PH_CODE;
          end
        end
        default: ;
      endcase
    end

    res.accepted  = q_entry_i.acc;
    res.cookie_ok = q_entry_i.acc &&
                    (phase_d == bootp_prs_pkg::PH_CODE || phase_d == bootp_prs_pkg::PH_LEN ||
                     phase_d == bootp_prs_pkg::PH_VALUE || phase_d == bootp_prs_pkg::PH_STOP);
    res.addr      = addr_d;

    if (out_push) begin
      phase_d = bootp_prs_pkg::PH_COOKIE;
      code_d  = '0;
      rem_d   = '0;
      val_d   = '0;
      cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= bootp_prs_pkg::PH_COOKIE;
      code_q  <= '0;
      rem_q   <= '0;
      val_q   <= '0;
      cnt_q   <= '0;
      addr_q  <= '0;
      owr_q   <= '0;
      ord_q   <= '0;
      ocnt_q  <= '0;
    end else begin
      phase_q <= phase_d;
      code_q  <= code_d;
      rem_q   <= rem_d;
      val_q   <= val_d;
      cnt_q   <= cnt_d;
      addr_q  <= addr_d;
      if (out_push) begin
        owr_q <= owr_q + bootp_prs_pkg::RPTR_W'(1);
      end
      if (out_pop) begin
        ord_q <= ord_q + bootp_prs_pkg::RPTR_W'(1);
      end
      ocnt_q <= ocnt_q + bootp_prs_pkg::RCNT_W'(out_push) - bootp_prs_pkg::RCNT_W'(out_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_push) begin
      out_mem_q[owr_q] <= res;
    end
  end

endmodule

// ----- hw/rtl/bootp_reply_option_parser_core.sv -----
// BOOTP reply parser. Takes a received reply one byte per clock (push/full) behind a
// 36-byte pseudo-header and returns one result word (empty/pop) on the last byte of
// each packet that starts while the block is not yet bound. A reply is accepted when
// its hardware type is 1, its address length is 6, its client hardware address equals
// the MAC written over the cfg port, and it reaches the vendor area; the offered
// address is then committed, the 99.130.83.99 cookie checked and the options walked
// up to a pad or end code or a mask option not four bytes long. The first address of
// mask, router, DNS, cookie-server and resource-server options lands in the address
// registers shown with every result. After one accepted reply the block is bound and
// swallows all bytes until reset. Rate: one byte per clock while the queue has room.
// The front end sees each byte in the cycle it is accepted; a four-word queue
// decouples it from the option walker, and a two-word result FIFO lets the option
// walker keep going while a result waits to be popped. A last byte that meets a full
// result FIFO waits in the queue; its result word shows on the ports once written there.
`timescale 1ns / 1ps

module bootp_reply_option_parser_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration: own MAC, first byte in the top bits
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bootp_prs_pkg::MAC_W-1:0]  cfg_client_mac_i,
  // Byte input
  input  logic                             push,
  output logic                             full,
  input  logic [7:0]                       data_byte_i,
  input  logic                             last_byte_i,
  // Result output
  output logic                             empty,
  input  logic                             pop,
  output logic                             accepted_o,
  output logic                             cookie_ok_o,
  output logic [bootp_prs_pkg::IP_W-1:0]   client_ip_o,
  output logic [bootp_prs_pkg::IP_W-1:0]   subnet_mask_o,
  output logic [bootp_prs_pkg::IP_W-1:0]   gateway_ip_o,
  output logic [bootp_prs_pkg::IP_W-1:0]   dns_ip_o,
  output logic [bootp_prs_pkg::IP_W-1:0]   auth_ip_o,
  output logic [bootp_prs_pkg::IP_W-1:0]   file_server_ip_o
);

  logic                   byte_valid;
  logic                   q_push, q_empty, q_pop;
  bootp_prs_pkg::entry_t  q_in, q_out;
  bootp_prs_pkg::result_t res;

  // Register is always writable; the user must write it only while idle, the block does not enforce this.
  assign cfg_ready_o = 1'b1;

  // A byte is taken whenever the queue has room, bound or not.
  assign byte_valid = push && !full;

  bootp_prs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_mac_i    (cfg_client_mac_i),
    .byte_valid_i (byte_valid),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .q_push_o     (q_push),
    .q_entry_o    (q_in)
  );

  bootp_prs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .entry_o (q_out)
  );

  bootp_prs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (!q_empty),
    .q_entry_i   (q_out),
    .q_pop_o     (q_pop),
    .res_empty_o (empty),
    .res_pop_i   (pop),
    .res_o       (res)
  );

  // Unpack the head result word.
  assign accepted_o       = res.accepted;
  assign cookie_ok_o      = res.cookie_ok;
  assign client_ip_o      = res.addr[bootp_prs_pkg::ADDR_CLIENT];
  assign subnet_mask_o    = res.addr[bootp_prs_pkg::ADDR_MASK];
  assign gateway_ip_o     = res.addr[bootp_prs_pkg::ADDR_ROUTER];
  assign dns_ip_o         = res.addr[bootp_prs_pkg::ADDR_DNS];
  assign auth_ip_o        = res.addr[bootp_prs_pkg::ADDR_AUTH];
  assign file_server_ip_o = res.addr[bootp_prs_pkg::ADDR_FILE];

endmodule

// ----- hw/rtl/bootp_prs_checker.sv -----
// Port-level checker for the BOOTP reply parser, bound to the top level.
// Uses the assertion macros of bootp_reply_option_parser_core_macros.svh.
`timescale 1ns / 1ps
`include "bootp_reply_option_parser_core_macros.svh"

module bootp_prs_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            empty,
  input logic                            pop,
  input logic                            accepted_o,
  input logic                            cookie_ok_o,
  input logic [bootp_prs_pkg::IP_W-1:0]  client_ip_o,
  input logic [bootp_prs_pkg::IP_W-1:0]  subnet_mask_o
);

  // The cookie is only reported for an accepted reply.
  `BPRS_ASSERT_NOW(a_cookie_needs_accept, !empty && cookie_ok_o, accepted_o)

  // An accepted reply is the last word ever produced.
  `BPRS_ASSERT_NEXT(a_accept_is_final, pop && !empty && accepted_o, empty)

  // A waiting word does not vanish.
  `BPRS_ASSERT_NEXT(a_word_stays, !empty && !pop, !empty)

  // A waiting word keeps its contents.
  `BPRS_ASSERT_NEXT(a_word_holds, !empty && !pop,
    $stable(accepted_o) && $stable(client_ip_o) && $stable(subnet_mask_o))

endmodule

bind bootp_reply_option_parser_core bootp_prs_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .empty         (empty),
  .pop           (pop),
  .accepted_o    (accepted_o),
  .cookie_ok_o   (cookie_ok_o),
  .client_ip_o   (client_ip_o),
  .subnet_mask_o (subnet_mask_o)
);

// ----- tb/bootp_reply_option_parser_core_test.sv -----
// Testbench for the BOOTP reply option parser: byte queue in, result queue out.
// Depends on bootp_prs_pkg and bootp_reply_option_parser_core; a tracker class
// predicts every result word from the accepted bytes and checks the popped words.
`timescale 1ns / 1ps

module bootp_reply_option_parser_core_test;
  import bootp_prs_pkg::*;

  localparam int DRAIN_CYCLES = 40;        // well above the result latency
  localparam int HOLD_CYCLES  = 300;       // long receiver hold-off
  localparam int TIMEOUT_NS   = 5_000_000;
  localparam logic [31:0] MAGIC_COOKIE = {8'd99, 8'd130, 8'd83, 8'd99};

  typedef enum {
    FLAW_NOISE,      // a few random bytes, never reaches the header checks
    FLAW_HTYPE,
    FLAW_HLEN,
    FLAW_MAC,
    FLAW_SHORT,      // matching header, ends well before the vendor area
    FLAW_CUT_VEND    // matching header, last byte just before the vendor area
  } flaw_e;

  // Tracks the parser byte by byte and holds the result words still due.
  class reply_tracker;
    logic [MAC_W-1:0] mac;
    int unsigned      ofs;
    bit               bound;
    bit               match;
    logic [IP_W-1:0]  offered;
    phase_e           phase;
    logic [7:0]       code;
    logic [7:0]       remaining;
    logic [IP_W-1:0]  value;
    int unsigned      value_cnt;
    logic [IP_W-1:0]  regs [NUM_ADDR];
    result_t          due_results[$];
    int unsigned      mismatches;
    int unsigned      checked;
    bit               reply_cookie;
    string            addr_name[NUM_ADDR] = '{"client_ip", "subnet_mask", "gateway_ip",
                                              "dns_ip", "auth_ip", "file_server_ip"};

    function new();
      mac = '0;
      bound = 1'b0;
      mismatches = 0;
      checked = 0;
      reply_cookie = 1'b0;
      foreach (regs[k]) regs[k] = '0;
      clear_packet();
    endfunction

    function void clear_packet();
      ofs = 0;
      match = 1'b1;
      offered = '0;
      phase = PH_COOKIE;
      code = '0;
      remaining = '0;
      value = '0;
      value_cnt = 0;
    endfunction

    function void walk_vendor(int unsigned vi, logic [7:0] b);
      case (phase)
        PH_COOKIE: begin
          if (vi > 3) phase = PH_BAD;
          else if (b != MAGIC_COOKIE[8*(3-vi) +: 8]) phase = PH_BAD;
          else if (vi == 3) phase = PH_CODE;
        end
        PH_CODE: begin
          if (b == OPT_PAD || b == OPT_END) begin
            phase = PH_STOP;
          end else begin
            code = b;
            phase = PH_LEN;
          end
        end
        PH_LEN: begin
          // a mask option of any length but four ends the walk
          if (code == OPT_MASK && b != MASK_LEN) begin
            phase = PH_STOP;
          end else begin
            remaining = b;
            value = '0;
            value_cnt = 0;
            phase = (b == 8'd0) ? PH_CODE : PH_VALUE;
          end
        end
        PH_VALUE: begin
          if (value_cnt < IP_BYTES) begin
            value = {value[IP_W-9:0], b};
            value_cnt++;
            if (value_cnt == IP_BYTES) begin
              case (code)
                OPT_MASK:       regs[ADDR_MASK]   = value;
                OPT_ROUTER:     regs[ADDR_ROUTER] = value;
                OPT_DNS:        regs[ADDR_DNS]    = value;
                OPT_COOKIE_SRV: regs[ADDR_AUTH]   = value;
                OPT_RLP_SRV:    regs[ADDR_FILE]   = value;
                default: ;
              endcase
            end
          end
          remaining--;
          if (remaining == 8'd0) phase = PH_CODE;
        end
        default: ;
      endcase
    endfunction

    function void note_byte(logic [7:0] b, bit last);
      int unsigned pos;
      bit          acc;
      result_t     r;
      if (bound) return;
      pos = ofs;
      if (pos < MAX_PACKET_BYTES) begin
        if (pos == OFS_HTYPE && b != HTYPE_ETHER) match = 1'b0;
        if (pos == OFS_HLEN && b != HLEN_ETHER) match = 1'b0;
        if (pos >= OFS_YIADDR && pos < OFS_YIADDR + IP_BYTES)
          offered = {offered[IP_W-9:0], b};
        if (pos >= OFS_CHADDR && pos < OFS_CHADDR + MAC_BYTES)
          if (b != mac[8*(MAC_BYTES-1-(pos-OFS_CHADDR)) +: 8]) match = 1'b0;
        if (match && pos >= OFS_VEND) begin
          if (pos == OFS_VEND) regs[ADDR_CLIENT] = offered;
          if (pos - OFS_VEND < VENDOR_BYTES) walk_vendor(pos - OFS_VEND, b);
        end
        ofs = pos + 1;
      end
      if (!last) return;
      acc = match && pos >= OFS_VEND;
      r.accepted = acc;
      r.cookie_ok = acc && phase >= PH_CODE && phase <= PH_STOP;
      for (int k = 0; k < NUM_ADDR; k++) r.addr[k] = regs[k];
      due_results.push_back(r);
      if (acc) begin
        bound = 1'b1;
        reply_cookie = r.cookie_ok;
      end
      clear_packet();
    endfunction

    task report(string field, logic [IP_W-1:0] got, logic [IP_W-1:0] want);
      $display("[%0t] mismatch on %s in result %0d: got %h, want %h",
               $time, field, checked, got, want);
      mismatches++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        report("unexpected result word", got.addr[ADDR_CLIENT], '0);
        return;
      end
      want = due_results.pop_front();
      if (got.accepted !== want.accepted)
        report("accepted", IP_W'(got.accepted), IP_W'(want.accepted));
      if (got.cookie_ok !== want.cookie_ok)
        report("cookie_ok", IP_W'(got.cookie_ok), IP_W'(want.cookie_ok));
      for (int k = 0; k < NUM_ADDR; k++)
        if (got.addr[k] !== want.addr[k]) report(addr_name[k], got.addr[k], want.addr[k]);
      checked++;
    endtask
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [MAC_W-1:0] cfg_mac;
  logic             push;
  logic             full;
  logic [7:0]       data_byte;
  logic             last_byte;
  logic             empty;
  logic             pop;
  logic             accepted;
  logic             cookie_ok;
  logic [IP_W-1:0]  client_ip;
  logic [IP_W-1:0]  subnet_mask;
  logic [IP_W-1:0]  gateway_ip;
  logic [IP_W-1:0]  dns_ip;
  logic [IP_W-1:0]  auth_ip;
  logic [IP_W-1:0]  file_server_ip;

  reply_tracker sb;
  logic [7:0]   octets[$];
  int unsigned  rx_hold_cycles = 0;
  bit           tx_steady = 1'b0;
  bit           rx_steady = 1'b0;
  int unsigned  packets_sent = 0;
  int unsigned  bytes_sent = 0;
  int unsigned  bytes_after_bind = 0;

  always #5 clk_i = ~clk_i;

  bootp_reply_option_parser_core DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_client_mac_i (cfg_mac),
    .push             (push),
    .full             (full),
    .data_byte_i      (data_byte),
    .last_byte_i      (last_byte),
    .empty            (empty),
    .pop              (pop),
    .accepted_o       (accepted),
    .cookie_ok_o      (cookie_ok),
    .client_ip_o      (client_ip),
    .subnet_mask_o    (subnet_mask),
    .gateway_ip_o     (gateway_ip),
    .dns_ip_o         (dns_ip),
    .auth_ip_o        (auth_ip),
    .file_server_ip_o (file_server_ip)
  );

  // One byte word through push/full; push stays high when the next word follows at once.
  task automatic send_octet(input logic [7:0] b, input bit is_last);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 11);
    if ($urandom_range(0, 31) == 0) tx_steady = !tx_steady;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    data_byte <= b;
    last_byte <= is_last;
    do @(posedge clk_i); while (full);
    sb.note_byte(b, is_last);
  endtask

  task automatic send_frame();
    bit was_bound;
    was_bound = sb.bound;
    for (int i = 0; i < octets.size(); i++) send_octet(octets[i], i == octets.size() - 1);
    packets_sent++;
    bytes_sent += octets.size();
    if (was_bound) bytes_after_bind += octets.size();
  endtask

  // Sender pause: every due result word must have come back, then settle.
  task automatic wait_drained();
    push <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mac(input logic [MAC_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_mac <= v;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.mac = v;
  endtask

  // Pseudo-header and BOOTP fixed part up to the vendor area, random filler elsewhere.
  task automatic build_header(input logic [7:0] htype, input logic [7:0] hlen,
                              input logic [MAC_W-1:0] mac_v, input logic [IP_W-1:0] ip);
    int         i;
    logic [7:0] b;
    octets.delete();
    for (i = 0; i < OFS_VEND; i++) begin
      b = 8'($urandom_range(0, 255));
      if (i == OFS_HTYPE) b = htype;
      if (i == OFS_HLEN) b = hlen;
      if (i >= OFS_YIADDR && i < OFS_YIADDR + IP_BYTES)
        b = ip[8*(IP_BYTES-1-(i-OFS_YIADDR)) +: 8];
      if (i >= OFS_CHADDR && i < OFS_CHADDR + MAC_BYTES)
        b = mac_v[8*(MAC_BYTES-1-(i-OFS_CHADDR)) +: 8];
      octets.push_back(b);
    end
  endtask

  task automatic fit_length(input int unsigned len);
    while (octets.size() < len) octets.push_back(8'($urandom_range(0, 255)));
    while (octets.size() > len) void'(octets.pop_back());
  endtask

  function automatic flaw_e pick_flaw();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return FLAW_NOISE;
    if (r == 4) return FLAW_HTYPE;
    if (r == 5) return FLAW_HLEN;
    if (r == 8) return FLAW_SHORT;
    return FLAW_MAC;
  endfunction

  // Mostly ends right after the flaw; now and then runs on into the vendor area.
  function automatic int unsigned tail_after(input int unsigned pos);
    if ($urandom_range(0, 7) == 0) return OFS_VEND + $urandom_range(1, 16);
    return pos + 1 + $urandom_range(0, 4);
  endfunction

  // A packet that the parser must turn down.
  task automatic send_rejected(input flaw_e flaw);
    int unsigned pos;
    int unsigned len;
    build_header(HTYPE_ETHER, HLEN_ETHER, sb.mac, $urandom);
    case (flaw)
      FLAW_NOISE: len = $urandom_range(1, 6);
      FLAW_HTYPE: begin
        octets[OFS_HTYPE] ^= 8'($urandom_range(1, 255));
        len = tail_after(OFS_HTYPE);
      end
      FLAW_HLEN: begin
        octets[OFS_HLEN] ^= 8'($urandom_range(1, 255));
        len = tail_after(OFS_HLEN);
      end
      FLAW_MAC: begin
        pos = OFS_CHADDR + $urandom_range(0, MAC_BYTES - 1);
        octets[pos] ^= 8'($urandom_range(1, 255));
        len = tail_after(pos);
      end
      FLAW_SHORT: len = $urandom_range(OFS_CHADDR + MAC_BYTES, OFS_CHADDR + MAC_BYTES + 16);
      default:    len = OFS_VEND;
    endcase
    fit_length(len);
    send_frame();
  endtask

  // A matching reply with a random option walk in the vendor area.
  task automatic send_reply();
    int unsigned shape;
    int unsigned vlen;
    int unsigned pick;
    int unsigned olen;
    logic [7:0]  ocode;
    build_header(HTYPE_ETHER, HLEN_ETHER, sb.mac, $urandom);
    shape = $urandom_range(0, 3);
    if (shape == 0) vlen = $urandom_range(1, 8);                        // cut within the first eight vendor bytes
    else if (shape == 1) vlen = VENDOR_BYTES + $urandom_range(1, 24);   // runs past the area
    else vlen = $urandom_range(16, VENDOR_BYTES);
    for (int i = 0; i < 4; i++) octets.push_back(MAGIC_COOKIE[8*(3-i) +: 8]);
    if ($urandom_range(0, 7) == 0) octets[OFS_VEND + $urandom_range(0, 3)] ^= 8'hA5;
    while (octets.size() < OFS_VEND + vlen) begin
      pick = $urandom_range(0, 15);
      if (pick >= 14 && shape == 1) pick = 11;
      if (pick <= 2) begin
        ocode = OPT_MASK;
        olen = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 8) : MASK_LEN;
      end else if (pick <= 10) begin
        case ((pick - 3) / 2)
          0:       ocode = OPT_ROUTER;
          1:       ocode = OPT_DNS;
          2:       ocode = OPT_COOKIE_SRV;
          default: ocode = OPT_RLP_SRV;
        endcase
        olen = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 10);
      end else if (pick <= 13) begin
        ocode = 8'($urandom_range(1, 254));
        olen = $urandom_range(0, 6);
      end else begin
        ocode = (pick == 14) ? OPT_END : OPT_PAD;
        olen = 0;
      end
      octets.push_back(ocode);
      if (pick < 14) begin
        octets.push_back(8'(olen));
        repeat (olen) octets.push_back(8'($urandom_range(0, 255)));
      end
    end
    // One reply in three, at random, goes past the offset counter's saturation point.
    if ($urandom_range(0, 2) == 0) fit_length(MAX_PACKET_BYTES + $urandom_range(1, 32));
    else fit_length(OFS_VEND + vlen);
    send_frame();
  endtask

  // Result side: pops with random gaps, honors a long hold-off when asked.
  initial begin
    int unsigned wait_left;
    result_t     got;
    wait_left = 0;
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        got.accepted = accepted;
        got.cookie_ok = cookie_ok;
        got.addr[ADDR_CLIENT] = client_ip;
        got.addr[ADDR_MASK] = subnet_mask;
        got.addr[ADDR_ROUTER] = gateway_ip;
        got.addr[ADDR_DNS] = dns_ip;
        got.addr[ADDR_AUTH] = auth_ip;
        got.addr[ADDR_FILE] = file_server_ip;
        sb.check_result(got);
        wait_left = rx_steady ? 0 : $urandom_range(0, 11);
        if ($urandom_range(0, 31) == 0) rx_steady = !rx_steady;
      end
      if (rx_hold_cycles != 0) begin
        wait_left = rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      if (wait_left != 0) begin
        pop <= 1'b0;
        wait_left--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("[%0t] timeout, %0d result words still due", $time, sb.due_results.size());
    $display("FAILURE");
    $finish;
  end

  initial begin
    sb = new();
    rst_ni = 1'b0;
    cfg_valid = 1'b0;
    cfg_mac = '0;
    push = 1'b0;
    data_byte = '0;
    last_byte = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // All-zero MAC; tiny packets with extreme byte values first.
    write_mac('0);
    octets = '{8'h00};
    send_frame();
    octets = '{8'hFF};
    send_frame();
    octets = '{8'hFF, 8'h00, 8'h80, 8'h7F};
    send_frame();
    for (int n = 0; n < 5; n++) send_rejected(flaw_e'(n));
    wait_drained();

    // All-ones MAC; receiver holds off so the byte queue and result FIFO back up.
    write_mac('1);
    rx_hold_cycles = HOLD_CYCLES;
    for (int n = 0; n < 30; n++) send_rejected(FLAW_NOISE);
    wait_drained();

    // Random MAC; a packet that stops one byte short of the vendor area.
    write_mac({16'($urandom), 32'($urandom)});
    send_rejected(FLAW_CUT_VEND);
    wait_drained();

    // New MAC, the one accepted reply, then a packet the bound parser must swallow.
    write_mac({16'($urandom), 32'($urandom)});
    send_reply();
    send_rejected(pick_flaw());
    wait_drained();

    $display("Sent %0d packets (%0d bytes, %0d after binding), checked %0d result words.",
             packets_sent, bytes_sent, bytes_after_bind, sb.checked);
    $display("Reply bound: %0d, cookie seen in reply: %0d.", sb.bound, sb.reply_cookie);
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
